[src/assert_macros.svh]
// Assertion macros for the RTL. Each check samples on the rising edge
// of clk and is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SPQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define SPQ_ASSERT_IMPL(lbl, ante, cons)
`define SPQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Types, sizes, codes and key compare for the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int DEPTH     = 64;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int ID_W      = 16;
  localparam int AGE_W     = 8;
  localparam int SEV_W     = 3;
  localparam int ARR_W     = 17;
  localparam int CNT_OUT_W = 7;
  localparam int STATUS_W  = 2;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [AGE_W-1:0] age;
    logic [SEV_W-1:0] severity;
    logic [ARR_W-1:0] arrival;
  } entry_t;

  typedef struct packed {
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 head_valid;
    entry_t               ent;
    logic [CNT_OUT_W-1:0] count;
  } result_t;

  typedef struct packed {
    logic          busy;
    logic [CW-1:0] count;
  } ctrl_stat_t;

  // True when a must be served strictly before b.
  function automatic logic goes_before(input entry_t a, input entry_t b);
    logic res;
    if (a.severity != b.severity) begin
      res = (a.severity < b.severity);
    end else begin
      res = (a.arrival < b.arrival);
    end
    return res;
  endfunction

  function automatic logic [CNT_OUT_W-1:0] cnt_out(input logic [CW-1:0] c);
    return CNT_OUT_W'(c);
  endfunction

endpackage

`default_nettype wire

[src/spq_if.sv]
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels carrying queue requests and queue results.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_in_if;
  import spq_pkg::*;
  logic             valid;
  logic             ready;
  logic             action;
  logic [ID_W-1:0]  entry_id;
  logic [AGE_W-1:0] entry_age;
  logic [SEV_W-1:0] entry_severity;
  logic [ARR_W-1:0] entry_arrival;

  modport source (
    output valid, action, entry_id, entry_age, entry_severity, entry_arrival,
    input  ready
  );
  modport sink (
    input  valid, action, entry_id, entry_age, entry_severity, entry_arrival,
    output ready
  );
endinterface

interface spq_out_if;
  import spq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic                 head_valid;
  logic [ID_W-1:0]      out_id;
  logic [AGE_W-1:0]     out_age;
  logic [SEV_W-1:0]     out_severity;
  logic [ARR_W-1:0]     out_arrival;
  logic [CNT_OUT_W-1:0] entry_count;

  modport source (
    output valid, status, head_valid, out_id, out_age, out_severity, out_arrival,
           entry_count,
    input  ready
  );
  modport sink (
    input  valid, status, head_valid, out_id, out_age, out_severity, out_arrival,
           entry_count,
    output ready
  );
endinterface

`default_nettype wire

[src/spq_mem.sv]
// ----------------------------------------------------------------------------
// spq_mem
// Entry store: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_mem (
  input  wire               clk,
  input  spq_pkg::mem_req_t mreq,
  output spq_pkg::entry_t   rd_data
);
  import spq_pkg::*;

  entry_t store [DEPTH];

  always_ff @(posedge clk) begin
    if (mreq.wr_en) begin
      store[mreq.wr_addr] <= mreq.wr_data;
    end
    if (mreq.rd_en) begin
      rd_data <= store[mreq.rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer that moves entries one slot per cycle through the store and
// compares each against the new key for an insert.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  spq_in_if.sink              req,
  output spq_pkg::mem_req_t   mreq,
  input  spq_pkg::entry_t     rd_data,
  output spq_pkg::result_t    res,
  output logic                res_valid,
  input  wire                 res_take,
  output spq_pkg::ctrl_stat_t stat
);
  import spq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_PUT  = 3'd2;
  localparam logic [2:0] S_REM  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic [AW-1:0] pos;
  entry_t        item;
  entry_t        head;
  entry_t        new_ent;
  logic          full;
  logic          ahead;
  logic          last_move;

  assign new_ent   = {req.entry_id, req.entry_age, req.entry_severity, req.entry_arrival};
  assign full      = (count == CW'(DEPTH));
  assign ahead     = goes_before(item, rd_data);
  assign last_move = ((CW'(pos) + CW'(1)) == count);

  assign req.ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign stat      = '{busy: (state != S_IDLE), count: count};

  // Reads run one slot ahead of writes, so each cycle moves one entry.
  always_comb begin
    mreq         = '0;
    mreq.wr_data = item;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.action == ACT_INSERT) begin
            if (count == '0) begin
              mreq.wr_en   = 1'b1;
              mreq.wr_addr = '0;
              mreq.wr_data = new_ent;
            end else if (!full) begin
              mreq.rd_en   = 1'b1;
              mreq.rd_addr = AW'(count - CW'(1));
            end
          end else if (count > CW'(1)) begin
            mreq.rd_en   = 1'b1;
            mreq.rd_addr = AW'(1);
          end
        end
      end
      S_INS: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = pos;
        if (ahead) begin
          mreq.wr_data = rd_data;
          if (pos != AW'(1)) begin
            mreq.rd_en   = 1'b1;
            mreq.rd_addr = pos - AW'(2);
          end
        end
      end
      S_PUT: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = '0;
      end
      S_REM: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = pos;
        mreq.wr_data = rd_data;
        if (!last_move) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = pos + AW'(2);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            item <= new_ent;
            if (req.action == ACT_INSERT) begin
              if (full) begin
                res   <= '{status: ST_OVERFLOW, head_valid: 1'b1, ent: head,
                           count: cnt_out(count)};
                state <= S_DONE;
              end else if (count == '0) begin
                head  <= new_ent;
                count <= CW'(1);
                res   <= '{status: ST_OK, head_valid: 1'b1, ent: new_ent,
                           count: cnt_out(CW'(1))};
                state <= S_DONE;
              end else begin
                pos            <= AW'(count);
                count          <= CW'(count + CW'(1));
                res.status     <= ST_OK;
                res.head_valid <= 1'b1;
                res.count      <= cnt_out(CW'(count + CW'(1)));
                state          <= S_INS;
              end
            end else begin
              if (count == '0) begin
                res   <= '{status: ST_EMPTY, head_valid: 1'b0, ent: '0,
                           count: cnt_out('0)};
                state <= S_DONE;
              end else begin
                count <= CW'(count - CW'(1));
                res   <= '{status: ST_OK, head_valid: 1'b1, ent: head,
                           count: cnt_out(CW'(count - CW'(1)))};
                pos   <= '0;
                state <= (count == CW'(1)) ? S_DONE : S_REM;
              end
            end
          end
        end
        S_INS: begin
          if (ahead) begin
            pos <= pos - AW'(1);
            if (pos == AW'(1)) begin
              state <= S_PUT;
            end
          end else begin
            res.ent <= head;
            state   <= S_DONE;
          end
        end
        S_PUT: begin
          head    <= item;
          res.ent <= item;
          state   <= S_DONE;
        end
        S_REM: begin
          if (pos == '0) begin
            head <= rd_data;
          end
          pos <= pos + AW'(1);
          if (last_move) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/sorted_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Priority queue of up to DEPTH entries kept in sorted order in a memory.
// ----------------------------------------------------------------------------
// A request word on req either inserts an entry (id, age, severity, arrival)
// or removes the head. Entries are ordered by lower severity, then earlier
// arrival, and first in, first out among equal keys. Each request yields one
// result word on rsp: a status, the head entry (or the removed entry on a
// remove) and the entry count after the request.
// An insert walks from the tail toward its slot, moving one entry per cycle
// through the memory's write port; a remove moves every entry up one slot.
// An insert passes through S_INS, and through S_PUT when it reaches slot 0,
// before its result is ready; a remove passes through S_REM. An overflow, an
// empty remove, a remove from a one-entry queue and an insert into an empty
// queue move no entries and go straight to the result. req.ready is low while
// a request is being worked on.
// The result sits in an output register; the next request is accepted while
// it waits, and a stalled rsp holds that word until taken. A second result
// waits inside the block until the register drains.
// Synchronous reset empties the queue and drops any pending result; the
// store needs no clearing pass since only filled slots are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_unit (
  input wire clk,
  input wire rst,
  spq_in_if.sink    req,
  spq_out_if.source rsp
);
  import spq_pkg::*;

`include "assert_macros.svh"

  mem_req_t   mreq;
  entry_t     rd_data;
  result_t    res;
  logic       res_valid;
  logic       res_take;
  ctrl_stat_t stat;
  logic       ovalid;
  result_t    ores;

  spq_mem u_mem (
    .clk     (clk),
    .mreq    (mreq),
    .rd_data (rd_data)
  );

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .mreq      (mreq),
    .rd_data   (rd_data),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take),
    .stat      (stat)
  );

  assign res_take = res_valid && (!ovalid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (res_take) begin
      ovalid <= 1'b1;
      ores   <= res;
    end else if (rsp.ready) begin
      ovalid <= 1'b0;
    end
  end

  assign rsp.valid        = ovalid;
  assign rsp.status       = ores.status;
  assign rsp.head_valid   = ores.head_valid;
  assign rsp.out_id       = ores.ent.id;
  assign rsp.out_age      = ores.ent.age;
  assign rsp.out_severity = ores.ent.severity;
  assign rsp.out_arrival  = ores.ent.arrival;
  assign rsp.entry_count  = ores.count;

  `SPQ_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready && stat.busy)
  `SPQ_ASSERT_IMPL(a_count_bound, 1'b1, stat.count <= CW'(DEPTH))
  `SPQ_ASSERT_IMPL(a_empty_result, res_take && res.status == ST_EMPTY, !res.head_valid && res.count == '0)
  `SPQ_ASSERT_NEXT(a_result_loaded, res_take, rsp.valid && rsp.status == $past(res.status))

endmodule

`default_nettype wire

[verif/sorted_priority_queue_unit_tb.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit_tb
// Self-checking bench for the sorted priority queue.
// ----------------------------------------------------------------------------
// Request words go into a queue that a clocked driver drains onto req. Each
// accepted word is applied to a shadow copy of the sorted store, and the
// result it should produce is queued. A clocked monitor on rsp compares
// every result word field by field with the oldest queued result. Directed
// words cover the key extremes, ties and empty removes. Random bursts then
// fill the store past full, drain it past empty and mix the two. Both sides
// idle at random in changing proportions.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int RANDOM_WORDS = 1200;
  localparam int STALL_LIMIT  = 3000;

  typedef struct packed {
    logic   action;
    entry_t ent;
  } queue_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  spq_in_if  req ();
  spq_out_if rsp ();

  sorted_priority_queue_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Driven registers, known from time zero.
  logic       drv_valid  = 1'b0;
  queue_req_t drv_word   = '0;
  logic       sink_ready = 1'b0;

  assign req.valid          = drv_valid;
  assign req.action         = drv_word.action;
  assign req.entry_id       = drv_word.ent.id;
  assign req.entry_age      = drv_word.ent.age;
  assign req.entry_severity = drv_word.ent.severity;
  assign req.entry_arrival  = drv_word.ent.arrival;
  assign rsp.ready          = sink_ready;

  queue_req_t pending_words[$];
  result_t    expected_results[$];
  int         total_words    = 1;
  int         accepted_words = 0;
  int         mismatches     = 0;
  int         stall_cycles   = 0;

  // Shadow of the sorted store.
  entry_t shadow_store[DEPTH];
  int     shadow_count = 0;

  // Applies one request to the shadow store and returns the result word.
  function automatic result_t queue_apply(input queue_req_t w);
    result_t r;
    int      pos;
    r = '0;
    if (w.action == ACT_INSERT) begin
      r.head_valid = 1'b1;
      if (shadow_count >= DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        // A new entry settles behind every stored entry with an equal key.
        pos = shadow_count;
        while (pos > 0 && {w.ent.severity, w.ent.arrival} <
                          {shadow_store[pos-1].severity, shadow_store[pos-1].arrival}) begin
          shadow_store[pos] = shadow_store[pos-1];
          pos--;
        end
        shadow_store[pos] = w.ent;
        shadow_count++;
        r.status = ST_OK;
      end
      r.ent = shadow_store[0];
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.status     = ST_OK;
      r.head_valid = 1'b1;
      r.ent        = shadow_store[0];
      for (int i = 0; i + 1 < shadow_count; i++) begin
        shadow_store[i] = shadow_store[i+1];
      end
      shadow_count--;
    end
    r.count = CNT_OUT_W'(shadow_count);
    return r;
  endfunction

  // Idle odds per side: first the sender idles lightly and the receiver
  // heavily, then the reverse, then neither idles.
  function automatic int idle_pct(input bit sender);
    int phase;
    phase = (accepted_words * 3) / total_words;
    if (phase == 0) begin
      return sender ? 31 : 74;
    end else if (phase == 1) begin
      return sender ? 74 : 31;
    end
    return 0;
  endfunction

  function automatic queue_req_t make_word(input logic act, input logic [ID_W-1:0] id,
                                           input logic [AGE_W-1:0] age,
                                           input logic [SEV_W-1:0] sev,
                                           input logic [ARR_W-1:0] arr);
    queue_req_t w;
    w.action       = act;
    w.ent.id       = id;
    w.ent.age      = age;
    w.ent.severity = sev;
    w.ent.arrival  = arr;
    return w;
  endfunction

  // Random word; narrow keys crowd into a few values so that ties are common.
  function automatic queue_req_t random_word(input int insert_pct, input bit narrow);
    logic [SEV_W-1:0] sev;
    logic [ARR_W-1:0] arr;
    logic             act;
    act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
    if (narrow) begin
      sev = SEV_W'($urandom_range(2, 3));
      arr = ARR_W'($urandom_range(100, 102));
    end else begin
      sev = SEV_W'($urandom_range(0, 7));
      if ($urandom_range(0, 7) == 0) begin
        arr = ARR_W'($urandom_range(0, 131071));
      end else begin
        arr = ARR_W'($urandom_range(0, 86399));
      end
    end
    return make_word(act, ID_W'($urandom), AGE_W'($urandom), sev, arr);
  endfunction

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      drv_valid      <= 1'b0;
      accepted_words <= 0;
    end else begin
      if (drv_valid && req.ready) begin
        expected_results.push_back(queue_apply(drv_word));
        accepted_words <= accepted_words + 1;
      end
      if (!drv_valid || req.ready) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          drv_word  <= pending_words.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      sink_ready <= 1'b0;
    end else begin
      if (rsp.valid && sink_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result word: status %0d id %h count %0d",
                     rsp.status, rsp.out_id, rsp.entry_count);
          end
        end else begin
          want = expected_results.pop_front();
          if (rsp.status !== want.status || rsp.head_valid !== want.head_valid ||
              rsp.out_id !== want.ent.id || rsp.out_age !== want.ent.age ||
              rsp.out_severity !== want.ent.severity ||
              rsp.out_arrival !== want.ent.arrival || rsp.entry_count !== want.count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch at %0t: want st %0d hv %0d id %h age %h sev %0d arr %0d cnt %0d",
                       $realtime, want.status, want.head_valid, want.ent.id, want.ent.age,
                       want.ent.severity, want.ent.arrival, want.count);
              $display("                         got  st %0d hv %0d id %h age %h sev %0d arr %0d cnt %0d",
                       rsp.status, rsp.head_valid, rsp.out_id, rsp.out_age,
                       rsp.out_severity, rsp.out_arrival, rsp.entry_count);
            end
          end
        end
      end
      sink_ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if (rst || (drv_valid && req.ready) || (rsp.valid && sink_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int kind;
    int len;
    int pct;
    int target;

    // Remove from an empty queue, then the key and payload extremes.
    pending_words.push_back(make_word(ACT_REMOVE, '1, '1, '1, '1));
    pending_words.push_back(make_word(ACT_INSERT, 16'hFFFF, 8'hFF, 3'd7, 17'h1FFFF));
    pending_words.push_back(make_word(ACT_INSERT, 16'h0000, 8'h00, 3'd0, 17'd0));
    // Fully equal keys must come out in arrival order of the words.
    pending_words.push_back(make_word(ACT_INSERT, 16'h0001, 8'h11, 3'd0, 17'd0));
    pending_words.push_back(make_word(ACT_INSERT, 16'h0002, 8'h22, 3'd0, 17'd0));
    pending_words.push_back(make_word(ACT_INSERT, 16'h0003, 8'h33, 3'd3, 17'd86399));
    pending_words.push_back(make_word(ACT_INSERT, 16'h0004, 8'h44, 3'd3, 17'd86400));
    pending_words.push_back(make_word(ACT_INSERT, 16'h0005, 8'h55, 3'd3, 17'd5));
    // Severity outranks arrival.
    pending_words.push_back(make_word(ACT_INSERT, 16'h0006, 8'h66, 3'd7, 17'd0));
    pending_words.push_back(make_word(ACT_INSERT, 16'h0007, 8'h77, 3'd6, 17'h1FFFF));
    for (int i = 0; i < 10; i++) begin
      pending_words.push_back(make_word(ACT_REMOVE, 16'(i), 8'(i), 3'(i), 17'(i)));
    end
    pending_words.push_back(make_word(ACT_REMOVE, '0, '0, '0, '0));

    // Random bursts: fill past full, drain past empty, mixed, tie-heavy.
    target = pending_words.size() + RANDOM_WORDS;
    while (pending_words.size() < target) begin
      kind = $urandom_range(0, 3);
      case (kind)
        0: begin
          pct = 96;
          len = $urandom_range(75, 100);
        end
        1: begin
          pct = 8;
          len = $urandom_range(30, 90);
        end
        2: begin
          pct = 50;
          len = $urandom_range(30, 90);
        end
        default: begin
          pct = 80;
          len = $urandom_range(30, 90);
        end
      endcase
      for (int i = 0; i < len; i++) begin
        pending_words.push_back(random_word(pct, kind == 3));
      end
    end
    total_words = pending_words.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || drv_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DEPTH + 20) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
